// ===== hw/rtl/bsfd_pkg.sv =====
package bsfd_pkg;

	localparam int PAYLOAD_MAX = 256;
	localparam int CHECK_BYTES = 4;

	localparam int CNT_MAX = (PAYLOAD_MAX > CHECK_BYTES) ? PAYLOAD_MAX : CHECK_BYTES;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int TAIL_W  = $clog2(CHECK_BYTES + 1);
	localparam int LANE_W  = (CHECK_BYTES > 1) ? $clog2(CHECK_BYTES) : 1;

	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'hff;
	localparam logic [7:0] NUL_BYTE  = 8'h00;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_TYPE    = 3'd1;
	localparam logic [2:0] PH_SEQ     = 3'd2;
	localparam logic [2:0] PH_NEXT    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_TAIL    = 3'd5;
	localparam logic [2:0] PH_CLOSE   = 3'd6;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TAIL_W-1:0] tail_t;
	typedef logic [LANE_W-1:0] lane_idx_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] ftype;
		logic [7:0] seq;
		logic [7:0] nxt;
		logic       ok;
	} res_t;

	function automatic tail_t tail_len(input cnt_t cnt);
		tail_t len;
		len = (cnt < CNT_W'(CHECK_BYTES)) ? TAIL_W'(cnt) : TAIL_W'(CHECK_BYTES);
		return len;
	endfunction

endpackage

// ===== hw/rtl/byte_stuffed_frame_deframer.sv =====
// Deframer for byte-stuffed frames: a 0x7e flag opens a frame, then type, sequence and
// next-frame header bytes, then payload with 0xff as escape, ended by a zero byte or the
// maximum length, then up to CHECK_BYTES raw check bytes compared with a lane-wise XOR of
// the payload, and a closing flag. Every payload byte comes out as a byte result
// (out_kind 0); the closing flag, or an unescaped flag in place of the sequence, next-frame
// or a payload byte, gives one status result (out_kind 1) with the header and check_ok.
// One byte is taken every clock cycle while in_stall is low, and its result, if any,
// goes into a result register or, while that holds a result, a one-entry skid stage in
// front of the output; in_stall only rises when both hold results not yet taken downstream.
module byte_stuffed_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic [7:0] frame_type,
	output logic [7:0] seq_number,
	output logic [7:0] next_indicator,
	output logic       check_ok
);
	import bsfd_pkg::*;

	logic [2:0] phase_q, phase_d;
	logic [7:0] hdr_type_q, hdr_type_d;
	logic [7:0] hdr_seq_q, hdr_seq_d;
	logic [7:0] hdr_next_q, hdr_next_d;
	cnt_t       cnt_q, cnt_d;
	logic       esc_q, esc_d;
	logic [7:0] lane_q [CHECK_BYTES];
	lane_idx_t  ptr_q, ptr_d;
	tail_t      tail_q, tail_d;
	logic       mism_q, mism_d;

	logic       acc;
	logic       start;
	logic       lane_en;
	logic       res_vld;
	res_t       res;
	logic       out_vld_q, skid_vld_q;
	res_t       out_q, skid_q;
	logic       take;

	assign acc      = in_valid && !in_stall;
	assign in_stall = skid_vld_q;
	assign take     = out_vld_q && !out_stall;

	always_comb begin
		phase_d    = phase_q;
		hdr_type_d = hdr_type_q;
		hdr_seq_d  = hdr_seq_q;
		hdr_next_d = hdr_next_q;
		cnt_d      = cnt_q;
		esc_d      = esc_q;
		ptr_d      = ptr_q;
		tail_d     = tail_q;
		mism_d     = mism_q;
		start      = 1'b0;
		lane_en    = 1'b0;
		res_vld    = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_TYPE: begin
				if (rx_byte == FLAG_BYTE) begin
					start = 1'b1;
				end else begin
					hdr_type_d = rx_byte;
					phase_d    = PH_SEQ;
				end
			end
			PH_SEQ, PH_NEXT: begin
				if (rx_byte == FLAG_BYTE) begin
					res_vld = 1'b1;
					res     = '{KIND_STATUS, 8'h00, hdr_type_q, hdr_seq_q, hdr_next_q, 1'b0};
					start   = 1'b1;
				end else if (phase_q == PH_SEQ) begin
					hdr_seq_d = rx_byte;
					phase_d   = PH_NEXT;
				end else begin
					hdr_next_d = rx_byte;
					phase_d    = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (!esc_q && rx_byte == ESC_BYTE) begin
					esc_d = 1'b1;
				end else if (!esc_q && rx_byte == FLAG_BYTE) begin
					res_vld = 1'b1;
					res     = '{KIND_STATUS, 8'h00, hdr_type_q, hdr_seq_q, hdr_next_q, 1'b0};
					start   = 1'b1;
				end else begin
					esc_d   = 1'b0;
					lane_en = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
					ptr_d   = (ptr_q == LANE_W'(CHECK_BYTES - 1)) ? '0 : ptr_q + LANE_W'(1);
					if (rx_byte == NUL_BYTE || cnt_d >= CNT_W'(PAYLOAD_MAX)) begin
						tail_d  = '0;
						phase_d = (tail_len(cnt_d) == '0) ? PH_CLOSE : PH_TAIL;
					end
					res_vld = 1'b1;
					res     = '{KIND_BYTE, rx_byte, 8'h00, 8'h00, 8'h00, 1'b0};
				end
			end
			PH_TAIL: begin
				if (tail_q < TAIL_W'(CHECK_BYTES) &&
				    lane_q[tail_q[LANE_W-1:0]] != rx_byte) begin
					mism_d = 1'b1;
				end
				tail_d = tail_q + TAIL_W'(1);
				if (tail_d >= tail_len(cnt_q)) begin
					phase_d = PH_CLOSE;
				end
			end
			PH_CLOSE: begin
				if (rx_byte == FLAG_BYTE) begin
					res_vld = 1'b1;
					res     = '{KIND_STATUS, 8'h00, hdr_type_q, hdr_seq_q, hdr_next_q, !mism_q};
					phase_d = PH_HUNT;
				end else begin
					mism_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == FLAG_BYTE) begin
					start = 1'b1;
				end
			end
		endcase
		if (start) begin
			phase_d    = PH_TYPE;
			hdr_type_d = '0;
			hdr_seq_d  = '0;
			hdr_next_d = '0;
			cnt_d      = '0;
			esc_d      = 1'b0;
			ptr_d      = '0;
			tail_d     = '0;
			mism_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hdr_type_q <= '0;
			hdr_seq_q  <= '0;
			hdr_next_q <= '0;
			cnt_q      <= '0;
			esc_q      <= 1'b0;
			ptr_q      <= '0;
			tail_q     <= '0;
			mism_q     <= 1'b0;
		end else if (acc) begin
			phase_q    <= phase_d;
			hdr_type_q <= hdr_type_d;
			hdr_seq_q  <= hdr_seq_d;
			hdr_next_q <= hdr_next_d;
			cnt_q      <= cnt_d;
			esc_q      <= esc_d;
			ptr_q      <= ptr_d;
			tail_q     <= tail_d;
			mism_q     <= mism_d;
		end
	end

	// per-lane xor accumulators, each lane only touches its own register
	for (genvar i = 0; i < CHECK_BYTES; i++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_q[i] <= '0;
			end else if (acc && start) begin
				lane_q[i] <= '0;
			end else if (acc && lane_en && ptr_q == LANE_W'(i)) begin
				lane_q[i] <= lane_q[i] ^ rx_byte;
			end
		end
	end

	// result register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= acc && res_vld;
				end
			end else if (acc && res_vld) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (acc && res_vld) begin
				out_q <= res;
			end
		end else if (acc && res_vld) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_vld_q;
	assign out_kind       = out_q.kind;
	assign out_byte       = out_q.data;
	assign frame_type     = out_q.ftype;
	assign seq_number     = out_q.seq;
	assign next_indicator = out_q.nxt;
	assign check_ok       = out_q.ok;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage holds a transfer while the result register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(take && skid_vld_q) |=> (out_vld_q && !skid_vld_q))
		else $error("skid transfer not moved into result register");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PAYLOAD_MAX))
		else $error("payload count above maximum length");

	a_tail_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAIL) |-> (tail_q < tail_len(cnt_q) && cnt_q != '0))
		else $error("check byte index out of range");

	a_no_result_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_HUNT) |=> (out_vld_q == $past(out_vld_q && !take) ||
			$past(skid_vld_q)))
		else $error("result produced while hunting for a flag");
`endif

endmodule

// ===== tb/byte_stuffed_frame_deframer_tb.sv =====
module byte_stuffed_frame_deframer_tb;
	import bsfd_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 11;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 250;
	localparam int HOLD_AFTER = 120;
	localparam int LINE_ITEMS = 1050;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIR_ROWS = 35;

	localparam bit CHK_PRED = 1'b0;
	localparam bit CHK_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] b;
		bit         typed;
		logic [7:0] ftype;
		logic [7:0] seq;
		logic [7:0] nxt;
		logic       ok;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{8'h11, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_STATUS, 8'h11, 8'h00, 8'h00, 1'b0},
		{8'hab, CHK_PRED, 24'h0, 1'b0},
		{8'hcd, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_STATUS, 8'hab, 8'hcd, 8'h00, 1'b0},
		{8'h01, CHK_PRED, 24'h0, 1'b0},
		{8'h02, CHK_PRED, 24'h0, 1'b0},
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_STATUS, 8'h01, 8'h02, 8'h00, 1'b1},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{ESC_BYTE, CHK_PRED, 24'h0, 1'b0},
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{8'h00, CHK_PRED, 24'h0, 1'b0},
		{8'h55, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_STATUS, 8'hff, 8'hff, 8'hff, 1'b0},
		{FLAG_BYTE, CHK_PRED, 24'h0, 1'b0},
		{8'h10, CHK_PRED, 24'h0, 1'b0},
		{8'h20, CHK_PRED, 24'h0, 1'b0},
		{8'h30, CHK_PRED, 24'h0, 1'b0},
		{8'h41, CHK_PRED, 24'h0, 1'b0},
		{FLAG_BYTE, CHK_STATUS, 8'h10, 8'h20, 8'h30, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       out_kind;
	logic [7:0] out_byte;
	logic [7:0] frame_type;
	logic [7:0] seq_number;
	logic [7:0] next_indicator;
	logic       check_ok;

	byte_stuffed_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.frame_type(frame_type),
		.seq_number(seq_number),
		.next_indicator(next_indicator),
		.check_ok(check_ok)
	);

	// deframer state as the line bytes have been accepted
	logic [2:0] ph;
	logic [7:0] h_type;
	logic [7:0] h_seq;
	logic [7:0] h_next;
	int         pay_cnt;
	bit         esc;
	logic [7:0] lane [CHECK_BYTES];
	int         tail_idx;
	bit         bad;

	res_t pending_results [$];
	int   errors = 0;
	int   fed = 0;
	int   frames = 0;
	int   full_frames = 0;
	int   results_seen = 0;
	int   bytes_out = 0;
	int   status_pass = 0;
	int   status_fail = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;
	bit   hold_on = 0;
	bit   held = 0;

	always #HALF_PERIOD clk = ~clk;

	function automatic void open_frame();
		h_type = 8'h00;
		h_seq = 8'h00;
		h_next = 8'h00;
		pay_cnt = 0;
		esc = 0;
		foreach (lane[i]) lane[i] = 8'h00;
		tail_idx = 0;
		bad = 0;
		ph = PH_TYPE;
	endfunction

	function automatic res_t status_of(input bit ok);
		res_t s;
		s = '0;
		s.kind = KIND_STATUS;
		s.ftype = h_type;
		s.seq = h_seq;
		s.nxt = h_next;
		s.ok = ok;
		return s;
	endfunction

	function automatic int check_len();
		return (pay_cnt < CHECK_BYTES) ? pay_cnt : CHECK_BYTES;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		bit got;
		got = 0;
		r = '0;
		case (ph)
			PH_TYPE: begin
				if (b == FLAG_BYTE) begin
					open_frame();
				end else begin
					h_type = b;
					ph = PH_SEQ;
				end
			end
			PH_SEQ, PH_NEXT: begin
				if (b == FLAG_BYTE) begin
					r = status_of(1'b0);
					got = 1;
					open_frame();
				end else if (ph == PH_SEQ) begin
					h_seq = b;
					ph = PH_NEXT;
				end else begin
					h_next = b;
					ph = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (!esc && b == ESC_BYTE) begin
					esc = 1;
				end else if (!esc && b == FLAG_BYTE) begin
					r = status_of(1'b0);
					got = 1;
					open_frame();
				end else begin
					esc = 0;
					lane[pay_cnt % CHECK_BYTES] ^= b;
					pay_cnt++;
					if (b == NUL_BYTE || pay_cnt >= PAYLOAD_MAX) begin
						tail_idx = 0;
						ph = (check_len() == 0) ? PH_CLOSE : PH_TAIL;
					end
					r.kind = KIND_BYTE;
					r.data = b;
					got = 1;
				end
			end
			PH_TAIL: begin
				if (tail_idx < CHECK_BYTES && lane[tail_idx] != b)
					bad = 1;
				tail_idx++;
				if (tail_idx >= check_len())
					ph = PH_CLOSE;
			end
			PH_CLOSE: begin
				if (b == FLAG_BYTE) begin
					r = status_of(!bad);
					got = 1;
					ph = PH_HUNT;
				end else begin
					bad = 1;
				end
			end
			default: begin
				ph = PH_HUNT;
				if (b == FLAG_BYTE)
					open_frame();
			end
		endcase
		return got;
	endfunction

	function automatic logic [7:0] non_flag();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == FLAG_BYTE)
			b = ~b;
		return b;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
		errors++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
		res_t r;
		bit   got;
		int   gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fed++;
		got = deframe_byte(b, r);
		if (typed)
			pending_results.push_back(want);
		else if (got)
			pending_results.push_back(r);
		gap = 0;
		if (hold_on) begin
			gap = 0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 39) == 0) begin
			burst_left = $urandom_range(20, 60);
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap = 0;
				10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
				17, 18: gap = $urandom_range(4, 10);
				default: gap = $urandom_range(20, 40);
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put(input logic [7:0] b);
		send_byte(b, CHK_PRED, '0);
	endtask

	task automatic put_payload(input logic [7:0] p);
		if (p == FLAG_BYTE || p == ESC_BYTE || $urandom_range(0, 15) == 0)
			put(ESC_BYTE);
		put(p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_frame(input bit full_len);
		logic [7:0] sum [CHECK_BYTES];
		logic [7:0] p;
		int         len;
		int         brk;
		int         tl;
		foreach (sum[i]) sum[i] = 8'h00;
		brk = $urandom_range(0, 29);
		put(FLAG_BYTE);
		if ($urandom_range(0, 7) == 0)
			put(FLAG_BYTE);
		put(non_flag());
		if (brk == 0) begin
			put(FLAG_BYTE);
			return;
		end
		put(non_flag());
		if (brk == 1) begin
			put(FLAG_BYTE);
			return;
		end
		put(non_flag());
		if (full_len) begin
			len = PAYLOAD_MAX;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: len = $urandom_range(1, 3);
				3, 4, 5, 6, 7: len = $urandom_range(4, 12);
				default: len = $urandom_range(13, 48);
			endcase
		end
		for (int i = 0; i < len; i++) begin
			if (brk == 2 && i == len - 1) begin
				put(FLAG_BYTE);
				return;
			end
			if (i == len - 1 && (!full_len || $urandom_range(0, 1) == 0))
				p = NUL_BYTE;
			else if ($urandom_range(0, 9) == 0)
				p = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
			else
				p = 8'($urandom_range(1, 255));
			sum[i % CHECK_BYTES] ^= p;
			put_payload(p);
		end
		tl = (len < CHECK_BYTES) ? len : CHECK_BYTES;
		for (int i = 0; i < tl; i++) begin
			p = sum[i];
			if ($urandom_range(0, 9) == 0)
				p ^= 8'(1 << $urandom_range(0, 7));
			put(p);
		end
		if ($urandom_range(0, 11) == 0)
			repeat ($urandom_range(1, 2)) put(non_flag());
		put(FLAG_BYTE);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) put(non_flag());
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, kind", out_kind, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_kind !== want.kind)
					report_mismatch("out_kind", out_kind, want.kind);
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (frame_type !== want.ftype)
					report_mismatch("frame_type", frame_type, want.ftype);
				if (seq_number !== want.seq)
					report_mismatch("seq_number", seq_number, want.seq);
				if (next_indicator !== want.nxt)
					report_mismatch("next_indicator", next_indicator, want.nxt);
				if (check_ok !== want.ok)
					report_mismatch("check_ok", check_ok, want.ok);
			end
			results_seen++;
			if (out_kind == KIND_BYTE)
				bytes_out++;
			else if (check_ok)
				status_pass++;
			else
				status_fail++;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results pending",
					idle_cycles, pending_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver stalls
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				hold_on = 1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_on = 0;
				held = 1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						out_stall <= 1'b0;
						repeat ($urandom_range(10, 40)) @(posedge clk);
					end
					9: begin
						out_stall <= 1'b1;
						repeat ($urandom_range(8, 30)) @(posedge clk);
					end
					default: begin
						repeat ($urandom_range(5, 20)) begin
							out_stall <= ($urandom_range(0, 3) == 0);
							@(posedge clk);
						end
					end
				endcase
			end
		end
	end

	initial begin
		res_t want;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		open_frame();
		ph = PH_HUNT;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			want = '0;
			want.kind = KIND_STATUS;
			want.ftype = DIRECTED[i].ftype;
			want.seq = DIRECTED[i].seq;
			want.nxt = DIRECTED[i].nxt;
			want.ok = DIRECTED[i].ok;
			send_byte(DIRECTED[i].b, DIRECTED[i].typed, want);
		end
		drain();

		while (fed < LINE_ITEMS) begin
			if (frames == 8 || (full_frames < 3 && $urandom_range(0, 59) == 0)) begin
				full_frames++;
				send_frame(1'b1);
			end else begin
				send_frame(1'b0);
			end
			frames++;
			if (frames == 30)
				drain();
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			report_mismatch("results never delivered, count", 0, pending_results.size());
		$display("fed %0d line bytes over %0d random frames (%0d at full payload length)",
			fed, frames, full_frames);
		$display("checked %0d payload bytes and %0d status results (%0d passing check)",
			bytes_out, status_pass + status_fail, status_pass);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
